// File: design/lct_pkg.sv
// lct_pkg: types, character constants and the per-byte word splitting function
// of the line command tokenizer
// no dependencies
package lct_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_EOM = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_CMD,
        PH_GAP,
        PH_PAY
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        phase_t phase;
        logic   emit;
        token_t tok;
    } split_t;

    typedef struct packed {
        phase_t phase;
        logic   cr_pending;
        logic   has_bytes;
    } line_state_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } step_out_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT)
            || (b == CHAR_FF) || (b == CHAR_CR);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) ? (b & ~CASE_BIT) : b;
    endfunction

    // one line byte, never a line feed, through the word splitter
    function automatic split_t split_byte(input phase_t ph, input logic [7:0] b);
        split_t r;
        r.phase    = ph;
        r.emit     = 1'b0;
        r.tok.kind = KIND_PAY;
        r.tok.data = b;
        case (ph)
            PH_PRE:
            begin
                if (!is_space(b))
                begin
                    r.emit     = 1'b1;
                    r.tok.kind = KIND_CMD;
                    r.tok.data = to_upper(b);
                    r.phase    = PH_CMD;
                end
            end
            PH_CMD:
            begin
                if (is_blank(b))
                begin
                    r.phase = PH_GAP;
                end
                else if (is_space(b))
                begin
                    r.emit  = 1'b1;
                    r.phase = PH_PAY;
                end
                else
                begin
                    r.emit     = 1'b1;
                    r.tok.kind = KIND_CMD;
                    r.tok.data = to_upper(b);
                end
            end
            PH_GAP:
            begin
                if (!is_blank(b))
                begin
                    r.emit  = 1'b1;
                    r.phase = PH_PAY;
                end
            end
            default:
            begin
                r.emit = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

// File: design/lct_if.sv
// lct_rx_if, lct_token_if: valid/ready channels for received bytes and for tokens
// no dependencies
interface lct_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lct_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic       run_last;

    modport source (output valid, output token_kind, output token_byte, output run_last,
                    input ready);
    modport sink (input valid, input token_kind, input token_byte, input run_last,
                  output ready);
endinterface

// File: design/line_command_tokenizer.sv
// line_command_tokenizer: top level, line state registers and a four-entry token queue
// depends on lct_pkg, lct_if, lct_step
// Each received byte turns at once into zero, one or two tokens (command bytes upper-cased,
// payload bytes, end of message) that wait in a four-entry queue and leave one per cycle
// while the sink is ready. One byte is taken per cycle whenever the queue holds at most two
// tokens, so bytes that give one token at most flow at one per cycle; a byte giving two (a
// released carriage return plus itself) can hold back later bytes until a token leaves. The
// rate is set by the single token output port. A held-back CR stays in the line state until
// the next byte shows whether a line feed follows. Reset clears all but the queue data.
module line_command_tokenizer
    import lct_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    lct_rx_if.sink          rx,
    lct_token_if.source     tok
);

    typedef struct packed {
        token_t tok;
        logic   last;
    } entry_t;

    line_state_t          state_reg;
    line_state_t          state_next;
    step_out_t            step;
    entry_t               queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic                 rx_fire;
    logic                 tok_fire;

    lct_step u_step (
        .state      (state_reg),
        .rx_byte    (rx.rx_byte),
        .state_next (state_next),
        .result     (step)
    );

    assign rx.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign rx_fire  = rx.valid & rx.ready;

    assign tok.valid      = (count_reg != '0);
    assign tok.token_kind = queue_reg[rd_ptr_reg].tok.kind;
    assign tok.token_byte = queue_reg[rd_ptr_reg].tok.data;
    assign tok.run_last   = queue_reg[rd_ptr_reg].last;
    assign tok_fire       = tok.valid & tok.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (rx_fire)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(step.count);
            count_next  = count_next + QCNT_W'(step.count);
        end
        if (tok_fire)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_PRE;
            state_reg.cr_pending <= 1'b0;
            state_reg.has_bytes  <= 1'b0;
            wr_ptr_reg           <= '0;
            rd_ptr_reg           <= '0;
            count_reg            <= '0;
        end
        else
        begin
            if (rx_fire)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token payload, no reset
    always_ff @(posedge clk)
    begin
        if (rx_fire && (step.count != 2'd0))
        begin
            queue_reg[wr_ptr_reg].tok  <= step.tok0;
            queue_reg[wr_ptr_reg].last <= (step.count == 2'd1);
        end
        if (rx_fire && (step.count == 2'd2))
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)].tok  <= step.tok1;
            queue_reg[wr_ptr_reg + QPTR_W'(1)].last <= 1'b1;
        end
    end

endmodule

// File: design/lct_step.sv
// lct_step: next line state and up to two tokens for one received byte
// depends on lct_pkg
module lct_step
    import lct_pkg::*;
(
    input  line_state_t state,
    input  logic [7:0]  rx_byte,
    output line_state_t state_next,
    output step_out_t   result
);

    split_t held;
    split_t cur;
    phase_t mid_phase;

    // released carriage return first, then the byte itself
    always_comb
    begin
        held      = split_byte(state.phase, CHAR_CR);
        mid_phase = state.cr_pending ? held.phase : state.phase;
        cur       = split_byte(mid_phase, rx_byte);
    end

    always_comb
    begin
        if (rx_byte == CHAR_LF)
        begin
            state_next.phase      = PH_PRE;
            state_next.cr_pending = 1'b0;
            state_next.has_bytes  = 1'b0;
        end
        else
        begin
            state_next.phase      = (rx_byte == CHAR_CR) ? mid_phase : cur.phase;
            state_next.cr_pending = (rx_byte == CHAR_CR);
            state_next.has_bytes  = state.has_bytes | state.cr_pending | (rx_byte != CHAR_CR);
        end
    end

    always_comb
    begin
        result.count     = 2'd0;
        result.tok0.kind = KIND_EOM;
        result.tok0.data = 8'h00;
        result.tok1      = cur.tok;
        if (rx_byte == CHAR_LF)
        begin
            result.count = {1'b0, state.has_bytes};
        end
        else
        begin
            if (state.cr_pending && held.emit)
            begin
                result.tok0  = held.tok;
                result.count = 2'd1;
            end
            else
            begin
                result.tok0 = cur.tok;
            end
            if ((rx_byte != CHAR_CR) && cur.emit)
            begin
                result.count = result.count + 2'd1;
            end
        end
    end

endmodule
